@@ hw/rtl/dgda_pkg.sv @@
// Shared types and constants for the density grid diffusion and advection block.
// Used by the top level, both port checkers and the testbench; depends on nothing else.
package dgda_pkg;

  localparam int GRID_SIDE_DEF = 64;

  localparam int DENS_W  = 32;
  localparam int VEL_W   = 16;
  localparam int CFG_W   = 16;
  localparam int COORD_W = 6;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;

  // item kinds carried on the input tuser
  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_STEP   = 2'd1,
    MODE_READ   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic REG_DELTA_TIME = 1'b0;
  localparam logic REG_GRID_SCALE = 1'b1;

  localparam logic [CFG_W-1:0] DT_RESET    = 16'd4;
  localparam logic [CFG_W-1:0] SCALE_RESET = 16'd256;

  localparam int RATE_BASE      = 256;
  localparam int DIFFUSE_DIV    = 100;
  localparam int A_MAX          = 65536;
  localparam int SHARE_SHIFT    = 19;
  localparam int ADV_SHIFT      = 9;
  localparam int MOVE_THRESHOLD = 655;

endpackage

@@ hw/rtl/density_grid_diffuse_advect.sv @@
// Top level of the density grid block: cell store, diffusion and advection sequencer.
// Depends on dgda_pkg and dgda_ram.
//
//  channel     | signals                               | contents
//  ------------+---------------------------------------+------------------------------------
//  item in     | s_axis_tvalid/tready/tdata/tuser      | tuser mode; tdata cell, density, vel
//  result out  | m_axis_tvalid/tready/tdata/tuser      | tdata density_out; tuser step_done
//  config      | cfg_we, cfg_index, cfg_data           | delta_time, grid_scale
//
// Write, read and unused items each take one memory read and one output load.
// A step works on the N = (GRID_SIDE-2)^2 interior cells; the 55-step shared
// divider in the advection pass dominates its run time.
// After reset the cell store is cleared, one entry a cycle (DEPTH entries, 4096 at
// GRID_SIDE 64); no item is accepted meanwhile. A stalled result holds intake.
module density_grid_diffuse_advect import dgda_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [5:0] cell_x, [11:6] cell_y, [43:12] density_in, [59:44] velocity_x,
  // [75:60] velocity_y, [79:76] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] density_out
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] step_done
  output logic                   m_axis_tuser,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int LOG   = $clog2(GRID_SIDE);
  localparam int AW    = 2 * LOG;
  localparam int DEPTH = 1 << AW;
  localparam int A_W   = DENS_W + 2 * VEL_W;
  localparam int NUM_W = 2 * DENS_W - ADV_SHIFT;
  localparam int DEN_W = CFG_W + $clog2(DIFFUSE_DIV);
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int RATE_W = CFG_W + 1;
  localparam logic [LOG-1:0] FIRST_IN = LOG'(1);
  localparam logic [LOG-1:0] LAST_IN  = LOG'(GRID_SIDE - 2);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_PEND, ST_DIV_A, ST_CLRB,
    ST_D_RD, ST_D_LD, ST_D_MUL, ST_N_RD, ST_N_WR, ST_C_RD, ST_C_WR,
    ST_CP_RD, ST_CP_WR,
    ST_V_RD, ST_V_LD, ST_V_M1, ST_V_M2, ST_V_DIV, ST_T_RD, ST_T_WR, ST_V_WR,
    ST_DONE
  } state_t;

  function automatic logic [DENS_W-1:0] sat_add(input logic [DENS_W-1:0] a,
                                                input logic [DENS_W-1:0] b);
    logic [DENS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DENS_W] ? '1 : s[DENS_W-1:0];
  endfunction

  state_t              state;
  logic [AW-1:0]       sweep;
  logic [LOG-1:0]      cx, cy;
  logic [2:0]          nk;
  logic                axis;
  logic [DENS_W-1:0]   d_reg, share, keep, cur, cur0, move_amt;
  logic [RATE_W-1:0]   a_rate;
  logic [VEL_W-1:0]    vx, vy;
  logic [DENS_W-1:0]   vr;
  logic                pend_read;
  logic                out_valid, out_done;
  logic [DENS_W-1:0]   out_data;
  logic [CFG_W-1:0]    delta_time, grid_scale;

  // shared divider
  logic [NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_den;
  logic [DEN_W-1:0]    div_rem;
  logic [CNT_W-1:0]    div_cnt;
  logic [DEN_W:0]      rem_sh;
  logic                rem_ge;
  logic                div_load;
  logic [NUM_W-1:0]    div_load_num;
  logic [DEN_W-1:0]    div_load_den;

  // memory ports
  logic                a_we, b_we;
  logic [AW-1:0]       a_waddr, a_raddr, b_waddr, b_raddr;
  logic [A_W-1:0]      a_wdata, a_rdata;
  logic [DENS_W-1:0]   b_wdata, b_rdata;

  // item fields
  logic [COORD_W-1:0]  in_x, in_y;
  logic [DENS_W-1:0]   in_den;
  logic [VEL_W-1:0]    in_vx, in_vy;
  mode_t               in_mode;
  logic                in_grid, s_accept, out_free;
  logic [AW-1:0]       item_addr, cell_addr, nb_addr, tgt_addr;
  logic [1:0]          ox, oy;
  logic [LOG-1:0]      nx, ny, tx, ty;
  logic [CFG_W-1:0]    scale1;
  logic [RATE_W-1:0]   rate;
  logic [VEL_W-1:0]    v_sel, v_abs;
  logic                last_cell;

  assign in_x    = s_axis_tdata[5:0];
  assign in_y    = s_axis_tdata[11:6];
  assign in_den  = s_axis_tdata[43:12];
  assign in_vx   = s_axis_tdata[59:44];
  assign in_vy   = s_axis_tdata[75:60];
  assign in_mode = mode_t'(s_axis_tuser);
  assign in_grid = (32'(in_x) < GRID_SIDE) && (32'(in_y) < GRID_SIDE);
  assign item_addr = {LOG'(in_x), LOG'(in_y)};

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_done;

  assign scale1 = (grid_scale == '0) ? CFG_W'(1) : grid_scale;
  assign rate   = RATE_W'(RATE_BASE) + RATE_W'(delta_time);

  assign cell_addr = {cx, cy};
  assign last_cell = (cx == LAST_IN) && (cy == LAST_IN);

  // neighbour offsets, 0 = minus one, 1 = none, 2 = plus one
  always_comb begin
    case (nk)
      3'd0:    begin ox = 2'd0; oy = 2'd0; end
      3'd1:    begin ox = 2'd0; oy = 2'd1; end
      3'd2:    begin ox = 2'd0; oy = 2'd2; end
      3'd3:    begin ox = 2'd1; oy = 2'd0; end
      3'd4:    begin ox = 2'd1; oy = 2'd2; end
      3'd5:    begin ox = 2'd2; oy = 2'd0; end
      3'd6:    begin ox = 2'd2; oy = 2'd1; end
      default: begin ox = 2'd2; oy = 2'd2; end
    endcase
  end
  assign nx = cx + LOG'(ox) - FIRST_IN;
  assign ny = cy + LOG'(oy) - FIRST_IN;
  assign nb_addr = {nx, ny};

  // move goes against the sign of the velocity
  assign v_sel = axis ? vy : vx;
  assign v_abs = v_sel[VEL_W-1] ? VEL_W'(~v_sel + 1'b1) : v_sel;
  always_comb begin
    tx = cx;
    ty = cy;
    if (!axis) begin
      tx = vx[VEL_W-1] ? cx + FIRST_IN : cx - FIRST_IN;
    end else begin
      ty = vy[VEL_W-1] ? cy + FIRST_IN : cy - FIRST_IN;
    end
  end
  assign tgt_addr = {tx, ty};

  // divider load
  always_comb begin
    div_load     = 1'b0;
    div_load_num = NUM_W'({rate, 16'b0});
    div_load_den = DEN_W'(scale1) * DEN_W'(DIFFUSE_DIV);
    if (state == ST_IDLE && s_accept && in_mode == MODE_STEP) begin
      div_load = 1'b1;
    end else if (state == ST_V_M2) begin
      div_load     = 1'b1;
      div_load_num = NUM_W'((64'(cur0) * 64'(vr)) >> ADV_SHIFT);
      div_load_den = DEN_W'(scale1);
    end
  end

  assign rem_sh = {div_rem, div_num[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_load) begin
      div_num <= div_load_num;
      div_den <= div_load_den;
      div_rem <= '0;
      div_cnt <= CNT_W'(NUM_W);
    end else if (div_cnt != '0) begin
      div_rem <= rem_ge ? DEN_W'(rem_sh - {1'b0, div_den}) : rem_sh[DEN_W-1:0];
      div_num <= {div_num[NUM_W-2:0], rem_ge};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // memory access per state
  always_comb begin
    a_we    = 1'b0;
    a_waddr = cell_addr;
    a_wdata = '0;
    a_raddr = cell_addr;
    b_we    = 1'b0;
    b_waddr = cell_addr;
    b_wdata = '0;
    b_raddr = cell_addr;
    case (state)
      ST_CLR: begin
        a_we    = 1'b1;
        a_waddr = sweep;
      end
      ST_IDLE: begin
        a_raddr = item_addr;
        if (s_accept && in_mode == MODE_WRITE && in_grid) begin
          a_we    = 1'b1;
          a_waddr = item_addr;
          a_wdata = {in_vy, in_vx, in_den};
        end
      end
      ST_CLRB: begin
        b_we    = 1'b1;
        b_waddr = sweep;
      end
      ST_N_RD: begin
        a_raddr = nb_addr;
        b_raddr = nb_addr;
      end
      ST_N_WR: begin
        if (a_rdata[DENS_W-1:0] < d_reg) begin
          b_we    = 1'b1;
          b_waddr = nb_addr;
          b_wdata = sat_add(b_rdata, share);
        end
      end
      ST_C_WR: begin
        b_we    = 1'b1;
        b_wdata = sat_add(b_rdata, keep);
      end
      ST_CP_RD: begin
        a_raddr = sweep;
        b_raddr = sweep;
      end
      ST_CP_WR: begin
        a_we    = 1'b1;
        a_waddr = sweep;
        a_wdata = {a_rdata[A_W-1:DENS_W], b_rdata};
      end
      ST_T_RD: begin
        a_raddr = tgt_addr;
      end
      ST_T_WR: begin
        a_we    = 1'b1;
        a_waddr = tgt_addr;
        a_wdata = {a_rdata[A_W-1:DENS_W], sat_add(a_rdata[DENS_W-1:0], move_amt)};
      end
      ST_V_WR: begin
        a_we    = 1'b1;
        a_wdata = {vy, vx, cur};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      sweep      <= '0;
      out_valid  <= 1'b0;
      delta_time <= DT_RESET;
      grid_scale <= SCALE_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DELTA_TIME: delta_time <= cfg_data;
          REG_GRID_SCALE: grid_scale <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_PEND || (state == ST_DONE && out_free)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_accept) begin
            pend_read <= (in_mode == MODE_READ) && in_grid;
            state     <= (in_mode == MODE_STEP) ? ST_DIV_A : ST_PEND;
          end
        end
        ST_PEND: begin
          out_done  <= 1'b0;
          out_data  <= pend_read ? a_rdata[DENS_W-1:0] : '0;
          state     <= ST_IDLE;
        end
        ST_DIV_A: begin
          if (div_cnt == '0) begin
            a_rate <= (div_num > NUM_W'(A_MAX)) ? RATE_W'(A_MAX) : div_num[RATE_W-1:0];
            sweep  <= '0;
            state  <= ST_CLRB;
          end
        end
        ST_CLRB: begin
          sweep <= sweep + 1'b1;
          if (sweep == '1) begin
            cx    <= FIRST_IN;
            cy    <= FIRST_IN;
            state <= ST_D_RD;
          end
        end
        ST_D_RD: state <= ST_D_LD;
        ST_D_LD: begin
          d_reg <= a_rdata[DENS_W-1:0];
          state <= ST_D_MUL;
        end
        ST_D_MUL: begin
          share <= DENS_W'((64'(d_reg) * 64'(a_rate)) >> SHARE_SHIFT);
          nk    <= '0;
          state <= ST_N_RD;
        end
        ST_N_RD: begin
          if (nk == '0) begin
            keep <= d_reg - {share[DENS_W-4:0], 3'b000};
          end
          state <= ST_N_WR;
        end
        ST_N_WR: begin
          // share refused by a neighbour stays in the cell
          if (!(a_rdata[DENS_W-1:0] < d_reg)) begin
            keep <= keep + share;
          end
          nk    <= nk + 1'b1;
          state <= (nk == 3'd7) ? ST_C_RD : ST_N_RD;
        end
        ST_C_RD: state <= ST_C_WR;
        ST_C_WR: begin
          if (last_cell) begin
            sweep <= '0;
            state <= ST_CP_RD;
          end else begin
            if (cy == LAST_IN) begin
              cy <= FIRST_IN;
              cx <= cx + 1'b1;
            end else begin
              cy <= cy + 1'b1;
            end
            state <= ST_D_RD;
          end
        end
        ST_CP_RD: state <= ST_CP_WR;
        ST_CP_WR: begin
          sweep <= sweep + 1'b1;
          if (sweep == '1) begin
            cx    <= FIRST_IN;
            cy    <= FIRST_IN;
            state <= ST_V_RD;
          end else begin
            state <= ST_CP_RD;
          end
        end
        ST_V_RD: state <= ST_V_LD;
        ST_V_LD: begin
          cur   <= a_rdata[DENS_W-1:0];
          cur0  <= a_rdata[DENS_W-1:0];
          vx    <= a_rdata[DENS_W+VEL_W-1:DENS_W];
          vy    <= a_rdata[A_W-1:DENS_W+VEL_W];
          axis  <= 1'b0;
          state <= ST_V_M1;
        end
        ST_V_M1: begin
          vr    <= DENS_W'(32'(rate) * 32'(v_abs));
          state <= ST_V_M2;
        end
        ST_V_M2: state <= ST_V_DIV;
        ST_V_DIV: begin
          if (div_cnt == '0) begin
            if (div_num > NUM_W'(MOVE_THRESHOLD)) begin
              if (div_num > NUM_W'(cur)) begin
                move_amt <= cur;
                cur      <= '0;
              end else begin
                move_amt <= div_num[DENS_W-1:0];
                cur      <= cur - div_num[DENS_W-1:0];
              end
              state <= ST_T_RD;
            end else if (!axis) begin
              axis  <= 1'b1;
              state <= ST_V_M1;
            end else begin
              state <= ST_V_WR;
            end
          end
        end
        ST_T_RD: state <= ST_T_WR;
        ST_T_WR: begin
          if (!axis) begin
            axis  <= 1'b1;
            state <= ST_V_M1;
          end else begin
            state <= ST_V_WR;
          end
        end
        ST_V_WR: begin
          if (last_cell) begin
            state <= ST_DONE;
          end else begin
            if (cy == LAST_IN) begin
              cy <= FIRST_IN;
              cx <= cx + 1'b1;
            end else begin
              cy <= cy + 1'b1;
            end
            state <= ST_V_RD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_done  <= 1'b1;
            out_data  <= '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  dgda_ram #(.WIDTH(A_W), .DEPTH(DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  dgda_ram #(.WIDTH(DENS_W), .DEPTH(DEPTH)) u_diff_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

endmodule

@@ hw/rtl/dgda_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dgda_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/dgda_checker.sv @@
// Port-level checks for the density grid block, bound to the top level.
// Depends on dgda_pkg.
module dgda_props import dgda_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [1:0]             s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_cell_result: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_axis_tuser != MODE_STEP |-> ##2 (m_axis_tvalid && !m_axis_tuser))
    else $error("cell request gave no result two cycles on");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_axis_tuser == MODE_STEP |=> !s_axis_tready)
    else $error("request taken during a step");

  a_step_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("step result carries density");

  a_stall_intake: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while result stalled");

endmodule

bind density_grid_diffuse_advect dgda_props u_dgda_checker (.*);

@@ sim/dgda_checker.sv @@
// Port checker for the density grid block: watches the request, result and register
// channels, predicts each result and compares it. Depends on dgda_pkg.
`timescale 1ns / 1ps

module dgda_checker import dgda_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tuser,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     steps_seen,
  output int                     reads_seen
);

  localparam int SIDE  = GRID_SIDE_DEF;
  localparam int CELLS = SIDE * SIDE;

  typedef struct {
    logic [DENS_W-1:0] density;
    logic              done;
  } cell_result_t;

  logic [DENS_W-1:0] dens_grid [CELLS];
  logic [DENS_W-1:0] spread_grid [CELLS];
  logic [VEL_W-1:0]  vx_grid [CELLS];
  logic [VEL_W-1:0]  vy_grid [CELLS];
  logic [CFG_W-1:0]  dt_reg, scale_reg;
  cell_result_t      result_q [$];

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic longint unsigned vel_mag(logic [VEL_W-1:0] v);
    int sv;
    sv = $signed(v);
    return (sv < 0) ? longint'(-sv) : longint'(sv);
  endfunction

  task automatic run_time_step();
    longint unsigned scl, rate, a, move, keep, den, ax, ay;
    logic [31:0] d, share, cur, m;
    int c, n, t;
    scl  = (scale_reg == 0) ? 1 : scale_reg;
    rate = RATE_BASE + dt_reg;
    a = (rate << 16) / (scl * DIFFUSE_DIV);
    if (a > A_MAX) a = A_MAX;
    for (int i = 0; i < CELLS; i++) spread_grid[i] = '0;
    for (int x = 1; x < SIDE - 1; x++)
      for (int y = 1; y < SIDE - 1; y++) begin
        c = x * SIDE + y;
        d = dens_grid[c];
        move = (longint'(d) * a) >> 16;
        share = move[34:3];
        keep = longint'(d) - 8 * longint'(share);
        for (int dx = -1; dx <= 1; dx++)
          for (int dy = -1; dy <= 1; dy++) begin
            if (dx != 0 || dy != 0) begin
              n = (x + dx) * SIDE + y + dy;
              if (dens_grid[n] < d) spread_grid[n] = sat_sum(spread_grid[n], share);
              else keep += share;
            end
          end
        spread_grid[c] = sat_sum(spread_grid[c], keep[31:0]);
      end
    den = 512 * scl;
    for (int i = 0; i < CELLS; i++) dens_grid[i] = spread_grid[i];
    for (int x = 1; x < SIDE - 1; x++)
      for (int y = 1; y < SIDE - 1; y++) begin
        c = x * SIDE + y;
        cur = dens_grid[c];
        // product wraps at 64 bits on purpose, as the fixed-point definition does
        ax = (longint'(cur) * (rate * vel_mag(vx_grid[c]))) / den;
        ay = (longint'(cur) * (rate * vel_mag(vy_grid[c]))) / den;
        if (ax > MOVE_THRESHOLD) begin
          m = (ax > cur) ? cur : ax[31:0];
          t = vx_grid[c][VEL_W-1] ? (x + 1) * SIDE + y : (x - 1) * SIDE + y;
          cur -= m;
          dens_grid[t] = sat_sum(dens_grid[t], m);
        end
        if (ay > MOVE_THRESHOLD) begin
          m = (ay > cur) ? cur : ay[31:0];
          t = vy_grid[c][VEL_W-1] ? c + 1 : c - 1;
          cur -= m;
          dens_grid[t] = sat_sum(dens_grid[t], m);
        end
        dens_grid[c] = cur;
      end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cell_result_t r, w;
    int c;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        dens_grid[i] = '0; vx_grid[i] = '0; vy_grid[i] = '0;
      end
      dt_reg = DT_RESET;
      scale_reg = SCALE_RESET;
      result_q.delete();
      fail_count = 0;
      steps_seen = 0;
      reads_seen = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 0);
        end else begin
          w = result_q.pop_front();
          if (m_axis_tdata !== w.density) report_mismatch("density", m_axis_tdata, w.density);
          if (m_axis_tuser !== w.done) report_mismatch("step_done", m_axis_tuser, w.done);
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_DELTA_TIME) dt_reg = cfg_data;
        else scale_reg = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        c = s_axis_tdata[5:0] * SIDE + s_axis_tdata[11:6];
        r.density = '0;
        r.done = 1'b0;
        case (s_axis_tuser)
          MODE_WRITE: begin
            dens_grid[c] = s_axis_tdata[43:12];
            vx_grid[c] = s_axis_tdata[59:44];
            vy_grid[c] = s_axis_tdata[75:60];
          end
          MODE_STEP: begin
            run_time_step();
            r.done = 1'b1;
            steps_seen++;
          end
          MODE_READ: begin
            r.density = dens_grid[c];
            reads_seen++;
          end
          default: ;
        endcase
        result_q.push_back(r);
      end
    end
    pending = result_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for density_grid_diffuse_advect: drives requests and register writes,
// stalls the result side, and gives the verdict. Depends on dgda_pkg and dgda_checker.
`timescale 1ns / 1ps

module tb_top import dgda_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2_500_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = 1'b0;
  logic [CFG_W-1:0]       cfg_data = '0;
  int fail_count, pending, steps_seen, reads_seen;
  bit calm = 1'b0;
  int items_sent = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  density_grid_diffuse_advect dut (.*);

  dgda_checker checker_i (.*);

  // result side: random stall bursts, none once the run is calm
  always @(negedge clk) begin
    if (rst || calm || $urandom_range(0, 3) != 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] kind, logic [5:0] x, logic [5:0] y,
                              logic [31:0] d, logic [15:0] vx, logic [15:0] vy);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0, vy, vx, d, y, x};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // hold requests until every result is back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_request(bit allow_noise);
    logic [1:0] kind;
    logic [5:0] x, y;
    logic [31:0] d;
    logic [15:0] vx, vy;
    // keep most traffic in a small patch so reads hit written cells
    if ($urandom_range(0, 9) < 7) begin
      x = 6'($urandom_range(0, 7)); y = 6'($urandom_range(0, 7));
    end else begin
      x = 6'($urandom); y = 6'($urandom);
    end
    case ($urandom_range(0, 3))
      0: d = $urandom_range(0, 4095) << 12;
      1: d = 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: d = $urandom;
    endcase
    vx = ($urandom_range(0, 4) == 0) ? '0 : 16'($urandom);
    vy = ($urandom_range(0, 4) == 0) ? '0 : 16'($urandom);
    kind = ($urandom_range(0, 1) == 0) ? MODE_WRITE : MODE_READ;
    if (allow_noise && $urandom_range(0, 19) == 0) kind = MODE_UNUSED;
    send_request(kind, x, y, d, vx, vy);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: corners, border, interior blob with extreme velocities
    send_request(MODE_WRITE, 6'd0, 6'd0, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000);
    send_request(MODE_WRITE, 6'd63, 6'd63, 32'h0001_0000, 16'h8000, 16'h7FFF);
    send_request(MODE_WRITE, 6'd4, 6'd4, 32'hFFFF_FFFF, 16'h0100, 16'hFF00);
    send_request(MODE_WRITE, 6'd5, 6'd4, 32'h0010_0000, 16'hFFFF, 16'h0001);
    send_request(MODE_WRITE, 6'd4, 6'd5, 32'h0000_0001, 16'h8000, 16'h7FFF);
    send_request(MODE_WRITE, 6'd62, 6'd1, 32'h8000_0000, 16'h0000, 16'h0000);
    send_request(MODE_WRITE, 6'd10, 6'd10, 32'h0000_0400, 16'h0200, 16'h0200);
    send_request(MODE_WRITE, 6'd20, 6'd20, 32'h1234_5678, 16'h0000, 16'hC000);
    send_request(MODE_READ, 6'd0, 6'd0, '0, '0, '0);
    send_request(MODE_READ, 6'd63, 6'd63, '0, '0, '0);
    send_request(MODE_READ, 6'd4, 6'd4, '0, '0, '0);
    send_request(MODE_READ, 6'd33, 6'd17, '0, '0, '0);
    send_request(MODE_UNUSED, 6'd4, 6'd4, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_request(MODE_READ, 6'd4, 6'd4, '0, '0, '0);
    send_request(MODE_STEP, 6'd0, 6'd0, '0, '0, '0);
    for (int i = 0; i < 6; i++)
      send_request(MODE_READ, 6'd3 + i[5:0], 6'd4, '0, '0, '0);
    drain();

    // fast time, finest scale: diffusion rate saturates
    write_reg(REG_DELTA_TIME, 16'hFFFF);
    write_reg(REG_GRID_SCALE, 16'd1);
    for (int i = 0; i < 130; i++) random_request(1'b1);
    send_request(MODE_STEP, '0, '0, '0, '0, '0);
    for (int i = 0; i < 20; i++) random_request(1'b0);
    drain();

    // zero time and a zero scale, treated as one
    write_reg(REG_DELTA_TIME, 16'd0);
    write_reg(REG_GRID_SCALE, 16'd0);
    for (int i = 0; i < 130; i++) random_request(1'b1);
    send_request(MODE_STEP, '0, '0, '0, '0, '0);
    for (int i = 0; i < 20; i++) random_request(1'b0);
    drain();

    // coarsest scale, random time, last stretch without idling
    write_reg(REG_DELTA_TIME, 16'($urandom));
    write_reg(REG_GRID_SCALE, 16'hFFFF);
    for (int i = 0; i < 100; i++) random_request(1'b1);
    calm = 1'b1;
    for (int i = 0; i < 50; i++) random_request(1'b1);
    drain();

    $display("sent %0d requests: %0d time steps, %0d reads, four register settings",
             items_sent, steps_seen, reads_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/dgda_pkg.sv
hw/rtl/dgda_ram.sv
hw/rtl/density_grid_diffuse_advect.sv
hw/rtl/dgda_checker.sv
sim/dgda_checker.sv
sim/tb_top.sv
